// ===== rtl/rpp_pkg.sv =====
// Shared types and constants for the prefixed radix numeral parser.
package rpp_pkg;

  localparam int unsigned ResultWidth = 32;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_PREFIX = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LOW_D = 8'h64;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_LOW_O = 8'h6f;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  localparam logic [3:0] DIGIT_LIMIT_BIN = 4'd2;
  localparam logic [3:0] DIGIT_LIMIT_OCT = 4'd8;
  localparam logic [3:0] DIGIT_LIMIT_DEC = 4'd10;
  localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

  typedef struct packed {
    logic [ResultWidth-1:0] value;
    logic                   error;
  } rpp_result_t;

endpackage

// ===== rtl/rpp_core.sv =====
// Parser state registers and the per-character next-state and result logic.
module rpp_core #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           char_i,
  input  logic                 last_i,
  output logic                 res_valid_o,
  output rpp_pkg::rpp_result_t res_o
);
  import rpp_pkg::*;

  logic [1:0]             phase_q, phase_d;
  logic [1:0]             radix_q, radix_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   err_q, err_d;

  logic                   raw_ok, digit_ok;
  logic [3:0]             digit;
  logic [VALUE_WIDTH-1:0] scaled;
  logic [VALUE_WIDTH-1:0] signed_val;
  logic signed [63:0]     ext_val;
  logic                   res_err;

  always_comb begin
    raw_ok = 1'b0;
    digit  = '0;
    if (char_i inside {[CH_ZERO:CH_NINE]}) begin
      raw_ok = 1'b1;
      digit  = 4'(char_i - CH_ZERO);
    end else if (radix_q == RADIX_HEX && (char_i inside {[CH_UP_A:CH_UP_F]})) begin
      raw_ok = 1'b1;
      digit  = 4'(char_i - CH_UP_A) + HEX_LETTER_BASE;
    end
    case (radix_q)
      RADIX_BIN: digit_ok = raw_ok && (digit < DIGIT_LIMIT_BIN);
      RADIX_OCT: digit_ok = raw_ok && (digit < DIGIT_LIMIT_OCT);
      RADIX_HEX: digit_ok = raw_ok;
      default:   digit_ok = raw_ok && (digit < DIGIT_LIMIT_DEC);
    endcase
  end

  always_comb begin
    case (radix_q)
      RADIX_BIN: scaled = acc_q << 1;
      RADIX_OCT: scaled = acc_q << 3;
      RADIX_HEX: scaled = acc_q << 4;
      default:   scaled = (acc_q << 3) + (acc_q << 1);
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    radix_d = radix_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    err_d   = err_q;
    if (phase_q == PH_START && char_i == CH_MINUS) begin
      neg_d   = 1'b1;
      phase_d = PH_PREFIX;
    end else if (phase_q == PH_START || phase_q == PH_PREFIX) begin
      phase_d = PH_DIGITS;
      case (char_i)
        CH_LOW_D: radix_d = RADIX_DEC;
        CH_LOW_B: radix_d = RADIX_BIN;
        CH_LOW_O: radix_d = RADIX_OCT;
        CH_LOW_X: radix_d = RADIX_HEX;
        default: begin
          radix_d = RADIX_DEC;
          err_d   = 1'b1;
        end
      endcase
    end else begin
      if (digit_ok) begin
        acc_d = scaled + VALUE_WIDTH'(digit);
      end else begin
        err_d = 1'b1;
      end
    end
  end

  // result from the post-update state
  assign res_err    = err_d || (phase_d != PH_DIGITS);
  assign signed_val = neg_d ? (VALUE_WIDTH'(0) - acc_d) : acc_d;
  assign ext_val    = 64'(signed'(signed_val));

  assign res_valid_o = accept_i && last_i;
  assign res_o.error = res_err;
  assign res_o.value = res_err ? '0 : ext_val[ResultWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      radix_q <= RADIX_DEC;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        phase_q <= PH_START;
        radix_q <= RADIX_DEC;
        neg_q   <= 1'b0;
        acc_q   <= '0;
        err_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        radix_q <= radix_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

// ===== rtl/rpp_out_reg.sv =====
// Output result register with valid/ready handshake.
module rpp_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  rpp_pkg::rpp_result_t in_data_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rpp_pkg::rpp_result_t out_data_o
);
  import rpp_pkg::*;

  logic        valid_q, valid_d;
  rpp_result_t data_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/prefixed_radix_numeral_parser_top.sv =====
// Top level of the prefixed radix numeral parser, one ASCII character per transaction.
// Throughput: one character per cycle while the output register is free or being read;
// the result lands in the output register in the cycle after the character marked last is accepted.
// Reset (rst_ni low, asynchronous) clears the parser state and the output valid.
module prefixed_radix_numeral_parser_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] char_code
  input  logic        s_axis_tlast_i,  // is_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] value
  output logic        m_axis_tuser_o   // [0] error
);
  import rpp_pkg::*;

  logic        accept;
  logic        res_valid;
  rpp_result_t res;
  rpp_result_t out_res;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  rpp_core #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .char_i     (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  rpp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_data_i  (res),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (out_res)
  );

  assign m_axis_tdata_o = out_res.value;
  assign m_axis_tuser_o = out_res.error;

endmodule

// ===== tb/numeral_parse_checker.sv =====
`timescale 1ns / 1ps
// Checker for the numeral parser: predicts each parsed numeral and compares results.
module numeral_parse_checker #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [7:0] char_code
  input  logic        s_tlast_i,   // is_last
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,   // [31:0] value
  input  logic        m_tuser_i,   // [0] error
  output int          mismatches_o,
  output int          pending_o
);
  import rpp_pkg::*;

  localparam int unsigned HexBase = 16;

  logic [1:0]             phase_q = PH_START;
  logic [1:0]             radix_q = RADIX_DEC;
  logic                   negative_q = 1'b0;
  logic [VALUE_WIDTH-1:0] accum_q = '0;
  logic                   bad_char_q = 1'b0;

  rpp_result_t expected_numerals[$];
  rpp_result_t oldest;
  int          mismatch_total = 0;
  int          outstanding = 0;
  int          delta;

  assign mismatches_o = mismatch_total;
  assign pending_o    = outstanding;

  function automatic int digit_of(logic [7:0] ch, logic [1:0] radix);
    int d;
    d = -1;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      d = int'(ch - CH_ZERO);
    end else if (radix == RADIX_HEX && ch >= CH_UP_A && ch <= CH_UP_F) begin
      d = int'(ch - CH_UP_A) + int'(HEX_LETTER_BASE);
    end
    case (radix)
      RADIX_BIN: if (d >= int'(DIGIT_LIMIT_BIN)) d = -1;
      RADIX_OCT: if (d >= int'(DIGIT_LIMIT_OCT)) d = -1;
      RADIX_DEC: if (d >= int'(DIGIT_LIMIT_DEC)) d = -1;
      default: ;
    endcase
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] numeral mismatch: %s", $time, msg);
    mismatch_total++;
  endtask

  task automatic clear_parse();
    phase_q    = PH_START;
    radix_q    = RADIX_DEC;
    negative_q = 1'b0;
    accum_q    = '0;
    bad_char_q = 1'b0;
  endtask

  task automatic parse_char(input logic [7:0] ch, input logic last);
    int                     d;
    logic [VALUE_WIDTH-1:0] base;
    logic [VALUE_WIDTH-1:0] magnitude;
    rpp_result_t            res;
    if (phase_q == PH_START && ch == CH_MINUS) begin
      negative_q = 1'b1;
      phase_q    = PH_PREFIX;
    end else if (phase_q == PH_START || phase_q == PH_PREFIX) begin
      case (ch)
        CH_LOW_D: radix_q = RADIX_DEC;
        CH_LOW_B: radix_q = RADIX_BIN;
        CH_LOW_O: radix_q = RADIX_OCT;
        CH_LOW_X: radix_q = RADIX_HEX;
        default: begin
          radix_q    = RADIX_DEC;
          bad_char_q = 1'b1;
        end
      endcase
      phase_q = PH_DIGITS;
    end else begin
      d = digit_of(ch, radix_q);
      if (d < 0) begin
        bad_char_q = 1'b1;
      end else begin
        case (radix_q)
          RADIX_BIN: base = VALUE_WIDTH'(DIGIT_LIMIT_BIN);
          RADIX_OCT: base = VALUE_WIDTH'(DIGIT_LIMIT_OCT);
          RADIX_HEX: base = VALUE_WIDTH'(HexBase);
          default:   base = VALUE_WIDTH'(DIGIT_LIMIT_DEC);
        endcase
        accum_q = accum_q * base + VALUE_WIDTH'(d);
      end
    end
    if (last) begin
      res.error = bad_char_q || (phase_q != PH_DIGITS);
      magnitude = negative_q ? -accum_q : accum_q;
      res.value = res.error ? '0 : 32'(signed'(magnitude));
      expected_numerals.push_back(res);
      clear_parse();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      expected_numerals.delete();
      outstanding <= 0;
    end else begin
      delta = 0;
      if (m_tvalid_i && m_tready_i) begin
        if (expected_numerals.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h error %b", m_tdata_i,
                                    m_tuser_i));
        end else begin
          oldest = expected_numerals.pop_front();
          delta--;
          if (m_tdata_i !== oldest.value)
            report_mismatch($sformatf("value got %h want %h", m_tdata_i, oldest.value));
          if (m_tuser_i !== oldest.error)
            report_mismatch($sformatf("error got %b want %b", m_tuser_i, oldest.error));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        parse_char(s_tdata_i, s_tlast_i);
        if (s_tlast_i) delta++;
      end
      outstanding <= outstanding + delta;
    end
  end

endmodule

// ===== tb/prefixed_radix_numeral_parser_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the numeral parser: stimulus, stall patterns, watchdog and verdict.
module prefixed_radix_numeral_parser_top_tb;
  import rpp_pkg::*;

  localparam int CharsPerPhase = 433;
  localparam int StallLimit    = 5000;
  localparam int TailCycles    = 8;

  localparam logic [7:0] CH_ONE   = CH_ZERO + 8'd1;
  localparam logic [7:0] CH_SEVEN = CH_ZERO + 8'd7;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  int mismatches;
  int pending;
  int send_idle_pct = 31;
  int recv_idle_pct = 74;
  int chars_sent = 0;
  int quiet_cycles = 0;

  logic [7:0] spelled[$];

  prefixed_radix_numeral_parser_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  numeral_parse_checker numeral_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("prefixed_radix_numeral_parser_top_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_spelled();
    foreach (spelled[i]) send_char(spelled[i], i == spelled.size() - 1);
    spelled.delete();
  endtask

  // hold the sender off until every numeral in flight has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] digit_char(int unsigned d);
    return (d < 10) ? CH_ZERO + 8'(d) : CH_UP_A + 8'(d - 10);
  endfunction

  task automatic spell_random();
    logic [1:0]  radix;
    int unsigned ndig;
    int unsigned limit;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 6))
        spelled.push_back(($urandom_range(3) == 0) ? CH_MINUS : 8'($urandom));
    end else begin
      if ($urandom_range(1) == 1) spelled.push_back(CH_MINUS);
      radix = 2'($urandom_range(3));
      case (radix)
        RADIX_BIN: limit = 32'(DIGIT_LIMIT_BIN);
        RADIX_OCT: limit = 32'(DIGIT_LIMIT_OCT);
        RADIX_HEX: limit = 16;
        default:   limit = 32'(DIGIT_LIMIT_DEC);
      endcase
      if ($urandom_range(19) == 0) begin
        spelled.push_back(8'($urandom));
      end else begin
        case (radix)
          RADIX_BIN: spelled.push_back(CH_LOW_B);
          RADIX_OCT: spelled.push_back(CH_LOW_O);
          RADIX_HEX: spelled.push_back(CH_LOW_X);
          default:   spelled.push_back(CH_LOW_D);
        endcase
      end
      ndig = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 10);
      repeat (ndig) begin
        if ($urandom_range(29) == 0) spelled.push_back(8'($urandom));
        else spelled.push_back(digit_char($urandom_range(limit - 1)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone minus, invalid prefix character, prefix with no digits
    spelled = '{CH_MINUS};
    send_spelled();
    spelled = '{8'hff};
    send_spelled();
    spelled = '{CH_LOW_D};
    send_spelled();
    // invalid input: NUL byte digit, lowercase hex letter, second minus as prefix
    spelled = '{CH_LOW_X, CH_UP_F, 8'h00};
    send_spelled();
    spelled = '{CH_MINUS, CH_LOW_B, CH_ONE, CH_ZERO, CH_ONE};
    send_spelled();
    spelled = '{CH_LOW_O, CH_SEVEN};
    send_spelled();
    spelled = '{CH_MINUS, CH_MINUS, CH_NINE};
    send_spelled();
    spelled = '{CH_LOW_X, CH_UP_A, CH_LOW_B};
    send_spelled();
    spelled = '{CH_LOW_D, CH_ONE, CH_NINE};
    send_spelled();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (chars_sent < (p + 1) * CharsPerPhase) begin
        spell_random();
        send_spelled();
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("prefixed_radix_numeral_parser_top_tb: done, clean");
    end else begin
      $display("prefixed_radix_numeral_parser_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rpp_pkg.sv
rtl/rpp_core.sv
rtl/rpp_out_reg.sv
rtl/prefixed_radix_numeral_parser_top.sv
tb/numeral_parse_checker.sv
tb/prefixed_radix_numeral_parser_top_tb.sv
